// ===== rtl/core/ngga_pkg.sv =====
// Package: shared constants, types and the line summary for the GGA parser.
`default_nettype none
package ngga_pkg;
    localparam int LINE_LIMIT_DEF = 100;
    localparam logic [1:0] KIND_OK = 2'd0;
    localparam logic [1:0] KIND_CSUM = 2'd1;
    localparam logic [1:0] KIND_TYPE = 2'd2;
    localparam logic [1:0] KIND_FEW = 2'd3;

    typedef enum logic [2:0] {
        PH_START, PH_SIGN, PH_INT, PH_FRAC, PH_STOP
    } t_phase;

    // summary of one finished sentence line, handed to the back end
    typedef struct packed {
        logic        ok;
        logic        is_gga;
        logic        enough;
        logic [31:0] lat_raw;
        logic [31:0] lon_raw;
        logic [31:0] alt;
        logic [15:0] hdop;
        logic [15:0] sats;
        logic [15:0] qual;
        logic [17:0] utc;
        logic        has_fix;
        logic        lat_neg;
        logic        lon_neg;
    } t_line;

    typedef struct packed {
        logic [1:0]  line_kind;
        logic        fix_valid;
        logic [30:0] latitude;
        logic [31:0] longitude;
        logic [24:0] altitude;
        logic [7:0]  satellites;
        logic [15:0] hdop;
        logic [7:0]  fix_quality;
        logic [17:0] utc_hhmmss;
        logic [31:0] sentence_total;
        logic [31:0] checksum_errors;
    } t_result;

    function automatic logic [31:0] cap32(input logic [63:0] v, input logic [31:0] c);
        cap32 = (v > {32'd0, c}) ? c : v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ngga_if.sv =====
// Interfaces: byte input channel and result channel.
`default_nettype none
interface ngga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface ngga_res_if;
    logic valid;
    logic ready;
    ngga_pkg::t_result res;
    modport source(output valid, output res, input ready);
    modport sink(input valid, input res, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ngga_front.sv =====
// Front end: line assembly, checksum and per-field digit accumulation.
`default_nettype none
module ngga_front #(
    parameter int LINE_LIMIT = ngga_pkg::LINE_LIMIT_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [7:0]        i_byte,
    output logic             o_ready,
    output logic             o_valid,
    output ngga_pkg::t_line  o_line,
    input  wire              i_ready
);
    import ngga_pkg::*;
    localparam logic [6:0] LIM = 7'(LINE_LIMIT - 1);

    logic [6:0] r_len, n_len;
    logic r_sent, n_sent, r_star, n_star, r_hstop, n_hstop, r_sfirst, n_sfirst;
    logic [7:0] r_xor, n_xor, r_given, n_given;
    logic [1:0] r_hcnt, n_hcnt, r_tm, n_tm;
    logic [4:0] r_fld, n_fld;
    logic [31:0] r_lat, n_lat, r_lon, n_lon, r_alt, n_alt;
    logic [15:0] r_hdop, n_hdop, r_sats, n_sats, r_qual, n_qual;
    logic [17:0] r_utc, n_utc;
    logic r_tm3, n_tm3;
    logic r_hlat, n_hlat, r_hlon, n_hlon, r_nlat, n_nlat, r_nlon, n_nlon;
    logic r_dlat, n_dlat, r_dlon, n_dlon, r_qpos, n_qpos;
    t_phase r_ph, n_ph;
    logic r_neg, n_neg, r_any, n_any;
    logic [2:0] r_frac, n_frac;
    logic r_ov, n_ov;
    t_line r_out, n_out;

    logic [7:0] c;
    logic is_dig, fire, term;
    logic [3:0] d, hv;
    logic hvalid;
    logic [2:0] nf;
    logic [31:0] p10;
    logic [16:0] h10;

    assign c = i_byte;
    assign fire = i_valid && o_ready;
    assign o_ready = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_line = r_out;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign d = 4'(c - 8'h30);
    assign term = (c == 8'd10) || (c == 8'd13);

    always_comb begin
        hvalid = 1'b1;
        hv = 4'd0;
        if (is_dig) hv = d;
        else if (c >= 8'h41 && c <= 8'h46) hv = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) hv = 4'(c - 8'h57);
        else hvalid = 1'b0;
    end

    always_comb begin
        n_len = r_len; n_sent = r_sent; n_star = r_star; n_hstop = r_hstop;
        n_sfirst = r_sfirst; n_xor = r_xor; n_given = r_given; n_hcnt = r_hcnt;
        n_tm = r_tm; n_tm3 = r_tm3; n_fld = r_fld; n_lat = r_lat; n_lon = r_lon;
        n_alt = r_alt; n_hdop = r_hdop; n_sats = r_sats; n_qual = r_qual;
        n_utc = r_utc; n_hlat = r_hlat; n_hlon = r_hlon; n_nlat = r_nlat;
        n_nlon = r_nlon; n_dlat = r_dlat; n_dlon = r_dlon; n_qpos = r_qpos;
        n_ph = r_ph; n_neg = r_neg; n_any = r_any; n_frac = r_frac;
        n_ov = r_ov && !i_ready; n_out = r_out;
        nf = (r_frac < 3'd7) ? r_frac + 3'd1 : r_frac;
        p10 = 32'd0;
        h10 = 17'd0;
        if (fire) begin
            if (term) begin
                n_len = 7'd0;
                if (r_len != 7'd0 && r_sent) begin
                    n_ov = 1'b1;
                    n_out.ok = r_star && !r_sfirst && r_hcnt == 2'd2 && r_xor == r_given;
                    n_out.is_gga = r_tm3;
                    n_out.enough = r_fld >= 5'd9;
                    n_out.lat_raw = r_lat;
                    n_out.lon_raw = r_lon;
                    n_out.alt = r_alt;
                    n_out.hdop = r_hdop;
                    n_out.sats = r_sats;
                    n_out.qual = r_qual;
                    n_out.utc = r_utc;
                    n_out.has_fix = r_hlat && r_hlon && r_qpos;
                    n_out.lat_neg = r_nlat ^ r_dlat;
                    n_out.lon_neg = r_nlon ^ r_dlon;
                end
            end else if (r_len >= LIM) begin
                n_len = 7'd0;
            end else begin
                n_len = r_len + 7'd1;
                if (r_len == 7'd0) begin
                    n_sent = (c == 8'h24);
                    n_xor = 8'd0; n_star = 1'b0; n_hcnt = 2'd0; n_given = 8'd0;
                    n_fld = 5'd0; n_tm = 2'd0; n_tm3 = 1'b0; n_lat = 32'd0;
                    n_lon = 32'd0; n_alt = 32'd0; n_hdop = 16'd0; n_sats = 16'd0;
                    n_qual = 16'd0; n_utc = 18'd0; n_hlat = 1'b0; n_hlon = 1'b0;
                    n_nlat = 1'b0; n_nlon = 1'b0; n_dlat = 1'b0; n_dlon = 1'b0;
                    n_qpos = 1'b0; n_sfirst = 1'b0; n_ph = PH_START; n_neg = 1'b0;
                    n_any = 1'b0; n_frac = 3'd0; n_hstop = 1'b0;
                end else if (r_sent) begin
                    if (r_star) begin
                        if (r_hcnt < 2'd2) begin
                            if (!r_hstop && hvalid) n_given = {r_given[3:0], hv};
                            else n_hstop = 1'b1;
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end else if (c == 8'h2A || c == 8'h2C) begin
                        // field end
                        if (c == 8'h2A) begin
                            n_star = 1'b1;
                            if (r_len == 7'd1) n_sfirst = 1'b1;
                        end else begin
                            n_xor = r_xor ^ c;
                            if (r_fld < 5'd19) n_fld = r_fld + 5'd1;
                        end
                        unique case (r_fld)
                            5'd2: begin
                                if (r_any) n_hlat = 1'b1;
                                if (r_neg) n_nlat = 1'b1;
                            end
                            5'd4: begin
                                if (r_any) n_hlon = 1'b1;
                                if (r_neg) n_nlon = 1'b1;
                            end
                            5'd6: if (r_neg) begin
                                n_qual = 16'd0;
                                n_qpos = 1'b0;
                            end
                            5'd7: if (r_neg) n_sats = 16'd0;
                            5'd8: if (r_neg) n_hdop = 16'd0;
                            5'd9: begin
                                if (r_neg)
                                    n_alt = 32'd0 - ((r_alt > 32'd999999) ? 32'd999999 : r_alt);
                                else if (r_alt > 32'd9999999)
                                    n_alt = 32'd9999999;
                            end
                            default: ;
                        endcase
                        n_ph = PH_START; n_neg = 1'b0; n_any = 1'b0; n_frac = 3'd0;
                    end else begin
                        n_xor = r_xor ^ c;
                        if (r_len >= 7'd3 && r_len <= 7'd5 && !r_tm3
                            && {5'd0, r_tm} == r_len - 7'd3
                            && c == ((r_len == 7'd5) ? 8'h41 : 8'h47)) begin
                            if (r_tm == 2'd2) n_tm3 = 1'b1;
                            else n_tm = r_tm + 2'd1;
                        end
                        if (r_ph == PH_START && (c == 8'h53 || c == 8'h57)) begin
                            if (r_fld == 5'd3) n_dlat = 1'b1;
                            if (r_fld == 5'd5) n_dlon = 1'b1;
                        end
                        if (r_ph != PH_STOP) begin
                            if (is_dig) begin
                                n_any = 1'b1;
                                if (r_ph == PH_FRAC) begin
                                    n_frac = nf;
                                    unique case (nf)
                                        3'd1: p10 = 32'd10000;
                                        3'd2: p10 = 32'd1000;
                                        3'd3: p10 = 32'd100;
                                        3'd4: p10 = 32'd10;
                                        3'd5: p10 = 32'd1;
                                        default: p10 = 32'd0;
                                    endcase
                                    case (nf)
                                        3'd1: h10 = 17'd10;
                                        3'd2: h10 = 17'd1;
                                        default: h10 = 17'd0;
                                    endcase
                                end else begin
                                    n_ph = PH_INT;
                                end
                                unique case (r_fld)
                                    5'd1: if (r_ph != PH_FRAC)
                                        n_utc = 18'(cap32({46'd0, r_utc} * 64'd10 + 64'(d),
                                                          32'd235959));
                                    5'd2: begin
                                        if (r_ph != PH_FRAC)
                                            n_lat = cap32({32'd0, r_lat} * 64'd10
                                                + 64'(d) * 64'd100000, 32'hFFFFFFFF);
                                        else if (nf <= 3'd5)
                                            n_lat = cap32({32'd0, r_lat} + 64'(d) * 64'(p10),
                                                          32'hFFFFFFFF);
                                    end
                                    5'd4: begin
                                        if (r_ph != PH_FRAC)
                                            n_lon = cap32({32'd0, r_lon} * 64'd10
                                                + 64'(d) * 64'd100000, 32'hFFFFFFFF);
                                        else if (nf <= 3'd5)
                                            n_lon = cap32({32'd0, r_lon} + 64'(d) * 64'(p10),
                                                          32'hFFFFFFFF);
                                    end
                                    5'd6: begin
                                        if (d != 4'd0) n_qpos = 1'b1;
                                        if (r_ph != PH_FRAC)
                                            n_qual = 16'(cap32({48'd0, r_qual} * 64'd10
                                                + 64'(d), 32'd65535));
                                    end
                                    5'd7: if (r_ph != PH_FRAC)
                                        n_sats = 16'(r_sats * 16'd10 + 16'(d));
                                    5'd8: begin
                                        if (r_ph != PH_FRAC)
                                            n_hdop = 16'(cap32({48'd0, r_hdop} * 64'd10
                                                + 64'(d) * 64'd100, 32'd65535));
                                        else
                                            n_hdop = 16'(cap32({48'd0, r_hdop}
                                                + 64'(d) * 64'(h10), 32'd65535));
                                    end
                                    5'd9: begin
                                        if (r_ph != PH_FRAC)
                                            n_alt = cap32({32'd0, r_alt} * 64'd10
                                                + 64'(d) * 64'd10, 32'd10000000);
                                        else if (nf == 3'd1)
                                            n_alt = cap32({32'd0, r_alt} + 64'(d),
                                                          32'd10000000);
                                    end
                                    default: ;
                                endcase
                            end else if (c == 8'h2E && r_ph != PH_FRAC) begin
                                n_ph = PH_FRAC;
                            end else if ((c == 8'h2B || c == 8'h2D) && r_ph == PH_START) begin
                                n_ph = PH_SIGN;
                                n_neg = (c == 8'h2D);
                            end else begin
                                n_ph = PH_STOP;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_sent <= 1'b0; r_star <= 1'b0; r_hstop <= 1'b0;
            r_sfirst <= 1'b0; r_xor <= '0; r_given <= '0; r_hcnt <= '0; r_tm <= '0;
            r_tm3 <= 1'b0; r_fld <= '0; r_lat <= '0; r_lon <= '0; r_alt <= '0;
            r_hdop <= '0; r_sats <= '0; r_qual <= '0; r_utc <= '0; r_hlat <= 1'b0;
            r_hlon <= 1'b0; r_nlat <= 1'b0; r_nlon <= 1'b0; r_dlat <= 1'b0;
            r_dlon <= 1'b0; r_qpos <= 1'b0; r_ph <= PH_START; r_neg <= 1'b0;
            r_any <= 1'b0; r_frac <= '0; r_ov <= 1'b0;
        end else begin
            r_len <= n_len; r_sent <= n_sent; r_star <= n_star; r_hstop <= n_hstop;
            r_sfirst <= n_sfirst; r_xor <= n_xor; r_given <= n_given; r_hcnt <= n_hcnt;
            r_tm <= n_tm; r_tm3 <= n_tm3; r_fld <= n_fld; r_lat <= n_lat; r_lon <= n_lon;
            r_alt <= n_alt; r_hdop <= n_hdop; r_sats <= n_sats; r_qual <= n_qual;
            r_utc <= n_utc; r_hlat <= n_hlat; r_hlon <= n_hlon; r_nlat <= n_nlat;
            r_nlon <= n_nlon; r_dlat <= n_dlat; r_dlon <= n_dlon; r_qpos <= n_qpos;
            r_ph <= n_ph; r_neg <= n_neg; r_any <= n_any; r_frac <= n_frac;
            r_ov <= n_ov;
        end
        r_out <= n_out;
    end
endmodule
`default_nettype wire

// ===== rtl/core/ngga_queue.sv =====
// Two-entry queue of line summaries between front and back end.
`default_nettype none
module ngga_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  ngga_pkg::t_line i_line,
    output logic            o_ready,
    output logic            o_valid,
    output ngga_pkg::t_line o_line,
    input  wire             i_ready
);
    import ngga_pkg::*;
    t_line r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_line = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_line;
    end
endmodule
`default_nettype wire

// ===== rtl/core/ngga_back.sv =====
// Back end: degree conversion, stored values, counters and result register.
`default_nettype none
module ngga_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  ngga_pkg::t_line   i_line,
    output logic              o_ready,
    output logic              o_valid,
    output ngga_pkg::t_result o_res,
    input  wire               i_ready
);
    import ngga_pkg::*;
    // 1e7 = 2^7 * 78125; whole degrees = ((raw >> 7) * ceil(2^42 / 78125)) >> 42
    localparam logic [25:0] DEG_RECIP = 26'd56294996;
    // x / 3 = (x * ceil(2^27 / 3)) >> 27, exact for x below 2^26
    localparam logic [25:0] THIRD_RECIP = 26'd44739243;

    // stage 1: split raw minutes and multiply; stage 2: update store and result
    logic r_v1;
    t_line r_l1;
    logic [31:0] r_latw, r_lonw;
    logic [25:0] r_latm, r_lonm;
    logic [31:0] r_slat, r_slon, r_salt, r_cnt, r_err;
    logic [7:0]  r_ssat, r_sq;
    logic [15:0] r_sh;
    logic [17:0] r_su;
    logic r_sfix, r_ov;
    t_result r_res;
    logic adv1, adv2;
    logic [31:0] latmag, lonmag;
    logic [31:0] lat_whole, lon_whole;
    logic [1:0] kind;

    assign o_valid = r_ov;
    assign o_res = r_res;
    assign adv2 = r_v1 && (!r_ov || i_ready);
    assign o_ready = !r_v1 || adv2;
    assign adv1 = i_valid && o_ready;

    function automatic logic [8:0] deg_of(input logic [31:0] raw);
        logic [50:0] prod;
        prod = {26'd0, raw[31:7]} * {25'd0, DEG_RECIP};
        deg_of = prod[50:42];
    endfunction

    function automatic logic [24:0] third(input logic [25:0] x);
        logic [51:0] prod;
        prod = {26'd0, x} * {26'd0, THIRD_RECIP};
        third = prod[51:27];
    endfunction

    always_comb begin
        lat_whole = {23'd0, deg_of(i_line.lat_raw)} * 32'd10000000;
        lon_whole = {23'd0, deg_of(i_line.lon_raw)} * 32'd10000000;
        latmag = cap32({32'd0, r_latw} + {39'd0, third(r_latm)}, 32'd900000000);
        lonmag = cap32({32'd0, r_lonw} + {39'd0, third(r_lonm)}, 32'd1800000000);
        if (!r_l1.ok) kind = KIND_CSUM;
        else if (!r_l1.is_gga) kind = KIND_TYPE;
        else if (!r_l1.enough) kind = KIND_FEW;
        else kind = KIND_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_ov <= 1'b0; r_slat <= '0; r_slon <= '0; r_salt <= '0;
            r_cnt <= '0; r_err <= '0; r_ssat <= '0; r_sq <= '0; r_sh <= '0;
            r_su <= '0; r_sfix <= 1'b0;
        end else begin
            if (adv1) r_v1 <= 1'b1;
            else if (adv2) r_v1 <= 1'b0;
            if (adv2) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (adv2) begin
                if (kind == KIND_CSUM) r_err <= r_err + 32'd1;
                if (kind == KIND_OK) begin
                    r_cnt <= r_cnt + 32'd1;
                    r_sq <= (r_l1.qual > 16'd255) ? 8'd255 : r_l1.qual[7:0];
                    r_su <= r_l1.utc;
                    r_ssat <= r_l1.sats[7:0];
                    r_sh <= r_l1.hdop;
                    r_sfix <= r_l1.has_fix;
                    if (r_l1.has_fix) begin
                        r_slat <= r_l1.lat_neg ? 32'd0 - latmag : latmag;
                        r_slon <= r_l1.lon_neg ? 32'd0 - lonmag : lonmag;
                        r_salt <= r_l1.alt;
                    end
                end
            end
        end
        if (adv1) begin
            r_l1 <= i_line;
            r_latw <= lat_whole;
            r_lonw <= lon_whole;
            r_latm <= 26'((i_line.lat_raw - lat_whole) * 32'd5);
            r_lonm <= 26'((i_line.lon_raw - lon_whole) * 32'd5);
        end
        if (adv2) begin
            r_res.line_kind <= kind;
            r_res.sentence_total <= r_cnt + ((kind == KIND_OK) ? 32'd1 : 32'd0);
            r_res.checksum_errors <= r_err + ((kind == KIND_CSUM) ? 32'd1 : 32'd0);
            if (kind == KIND_OK) begin
                r_res.fix_quality <= (r_l1.qual > 16'd255) ? 8'd255 : r_l1.qual[7:0];
                r_res.utc_hhmmss <= r_l1.utc;
                r_res.satellites <= r_l1.sats[7:0];
                r_res.hdop <= r_l1.hdop;
                r_res.fix_valid <= r_l1.has_fix;
                if (r_l1.has_fix) begin
                    r_res.latitude <= 31'(r_l1.lat_neg ? 32'd0 - latmag : latmag);
                    r_res.longitude <= r_l1.lon_neg ? 32'd0 - lonmag : lonmag;
                    r_res.altitude <= r_l1.alt[24:0];
                end else begin
                    r_res.latitude <= r_slat[30:0];
                    r_res.longitude <= r_slon;
                    r_res.altitude <= r_salt[24:0];
                end
            end else begin
                r_res.fix_quality <= r_sq;
                r_res.utc_hhmmss <= r_su;
                r_res.satellites <= r_ssat;
                r_res.hdop <= r_sh;
                r_res.fix_valid <= r_sfix;
                r_res.latitude <= r_slat[30:0];
                r_res.longitude <= r_slon;
                r_res.altitude <= r_salt[24:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nmea_gga_sentence_parser.sv =====
// Top level: NMEA GGA sentence parser, front end, queue and back end.
// Throughput: one byte per cycle unless stalled; the front end updates line
// state each byte. The result of a terminator word passes the front register, queue,
// conversion stage and result register, and stalls can hold it back on the way.
// Reset: synchronous active-low i_rst_n clears line state, stores and counters.
`default_nettype none
module nmea_gga_sentence_parser #(
    parameter int LINE_LIMIT = ngga_pkg::LINE_LIMIT_DEF
) (
    input wire i_clk,
    input wire i_rst_n,
    ngga_byte_if.sink  i_in,
    ngga_res_if.source o_out
);
    import ngga_pkg::*;
    logic f_v, f_r, q_v, q_r;
    t_line f_l, q_l;

    ngga_front #(.LINE_LIMIT(LINE_LIMIT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .i_byte(i_in.rx_byte),
        .o_ready(i_in.ready), .o_valid(f_v), .o_line(f_l), .i_ready(f_r));
    ngga_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_v), .i_line(f_l), .o_ready(f_r),
        .o_valid(q_v), .o_line(q_l), .i_ready(q_r));
    ngga_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v), .i_line(q_l), .o_ready(q_r),
        .o_valid(o_out.valid), .o_res(o_out.res), .i_ready(o_out.ready));
endmodule
`default_nettype wire

// ===== bench/nmea_gga_sentence_parser_test.sv =====
// Self-checking bench for the NMEA GGA parser: directed lines, then random lines.
`default_nettype none
module nmea_gga_sentence_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ngga_pkg::*;

    localparam int LIMIT = 100;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    ngga_byte_if in_ch();
    ngga_res_if out_ch();

    nmea_gga_sentence_parser #(.LINE_LIMIT(LIMIT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // ---------------------------------------------------------------
    // Predictor state: line assembly, current-line parse, stored fix
    // ---------------------------------------------------------------
    int unsigned ln_len;
    bit          ln_sent, star, hex_stop, star_first;
    bit [7:0]    xsum, given;
    int unsigned hex_cnt, fld, type_prog;
    bit [31:0]   w_lat, w_lon, w_alt, w_hdop, w_sats, w_qual, w_utc;
    bit          has_lat, has_lon, lat_neg, lat_dir, lon_neg, lon_dir, qpos;
    t_phase      ph;
    bit          n_neg, n_any;
    int unsigned n_frac;
    bit [31:0]   s_lat, s_lon, s_alt, s_hdop, s_utc, gga_count, csum_count;
    bit [7:0]    s_sats, s_qual;
    bit          s_fix;

    t_result     expected_results[$];
    int          errors = 0;

    function automatic bit [31:0] sat(longint unsigned v, longint unsigned c);
        return (v > c) ? c[31:0] : v[31:0];
    endfunction

    function automatic longint unsigned pw10(int n);
        longint unsigned r = 1;
        for (int k = 0; k < n; k++) r *= 10;
        return r;
    endfunction

    function automatic bit [31:0] add_minutes(bit [31:0] r, int unsigned d, bit fr);
        if (!fr) return sat(longint'(r) * 10 + d * 100000, 32'hFFFF_FFFF);
        if (n_frac > 5) return r;
        return sat(longint'(r) + d * pw10(5 - n_frac), 32'hFFFF_FFFF);
    endfunction

    function automatic void digit(int unsigned d, bit fr);
        case (fld)
            1: if (!fr) w_utc = sat(longint'(w_utc) * 10 + d, 235959);
            2: w_lat = add_minutes(w_lat, d, fr);
            4: w_lon = add_minutes(w_lon, d, fr);
            6: begin
                if (d != 0) qpos = 1;
                if (!fr) w_qual = sat(longint'(w_qual) * 10 + d, 65535);
            end
            7: if (!fr) w_sats = (w_sats * 10 + d) & 32'hFFFF;
            8: if (!fr) w_hdop = sat(longint'(w_hdop) * 10 + d * 100, 65535);
               else if (n_frac <= 2)
                   w_hdop = sat(longint'(w_hdop) + d * pw10(2 - n_frac), 65535);
            9: if (!fr) w_alt = sat(longint'(w_alt) * 10 + d * 10, 10000000);
               else if (n_frac == 1) w_alt = sat(longint'(w_alt) + d, 10000000);
            default: ;
        endcase
    endfunction

    function automatic void number_char(bit [7:0] c);
        if (ph == PH_START && (c == "S" || c == "W")) begin
            if (fld == 3) lat_dir = 1;
            if (fld == 5) lon_dir = 1;
        end
        if (ph == PH_STOP) return;
        if (c >= "0" && c <= "9") begin
            n_any = 1;
            if (ph == PH_FRAC) begin
                if (n_frac < 7) n_frac++;
                digit(c - "0", 1);
            end else begin
                ph = PH_INT;
                digit(c - "0", 0);
            end
        end else if (c == "." && ph != PH_FRAC) ph = PH_FRAC;
        else if ((c == "+" || c == "-") && ph == PH_START) begin
            ph = PH_SIGN;
            n_neg = (c == "-");
        end else ph = PH_STOP;
    endfunction

    function automatic void close_field();
        bit [31:0] m;
        case (fld)
            2: begin if (n_any) has_lat = 1; if (n_neg) lat_neg = 1; end
            4: begin if (n_any) has_lon = 1; if (n_neg) lon_neg = 1; end
            6: if (n_neg) begin w_qual = 0; qpos = 0; end
            7: if (n_neg) w_sats = 0;
            8: if (n_neg) w_hdop = 0;
            9: if (n_neg) begin
                m = (w_alt > 999999) ? 999999 : w_alt;
                w_alt = -m;
            end else if (w_alt > 9999999) w_alt = 9999999;
            default: ;
        endcase
        ph = PH_START; n_neg = 0; n_any = 0; n_frac = 0;
    endfunction

    function automatic int hexval(bit [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic void open_line(bit [7:0] c);
        ln_sent = (c == "$");
        xsum = 0; star = 0; hex_cnt = 0; given = 0; fld = 0; type_prog = 0;
        w_lat = 0; w_lon = 0; w_alt = 0; w_hdop = 0; w_sats = 0; w_qual = 0; w_utc = 0;
        has_lat = 0; has_lon = 0; lat_neg = 0; lat_dir = 0; lon_neg = 0; lon_dir = 0;
        qpos = 0; star_first = 0;
        ph = PH_START; n_neg = 0; n_any = 0; n_frac = 0; hex_stop = 0;
    endfunction

    function automatic void sentence_char(int unsigned p, bit [7:0] c);
        int v;
        if (star) begin
            if (hex_cnt < 2) begin
                v = hexval(c);
                if (!hex_stop && v >= 0) given = {given[3:0], v[3:0]};
                else hex_stop = 1;
                hex_cnt++;
            end
            return;
        end
        if (c == "*") begin
            star = 1;
            if (p == 1) star_first = 1;
            close_field();
            return;
        end
        xsum ^= c;
        if (p >= 3 && p <= 5 && type_prog == p - 3 && c == ((p == 5) ? "A" : "G"))
            type_prog++;
        if (c == ",") begin
            close_field();
            if (fld < 19) fld++;
        end else number_char(c);
    endfunction

    function automatic bit [31:0] degrees(bit [31:0] raw, bit neg, longint unsigned cap);
        longint unsigned whole = raw / 10000000;
        longint unsigned mins = raw % 10000000;
        bit [31:0] mag = sat(whole * 10000000 + mins * 5 / 3, cap);
        return neg ? -mag : mag;
    endfunction

    function automatic t_result close_line();
        t_result r;
        bit ok = star && !star_first && hex_cnt >= 2 && xsum == given;
        if (!ok) begin
            csum_count++;
            r.line_kind = KIND_CSUM;
        end else if (type_prog != 3) r.line_kind = KIND_TYPE;
        else if (fld < 9) r.line_kind = KIND_FEW;
        else begin
            r.line_kind = KIND_OK;
            gga_count++;
            s_qual = (w_qual > 255) ? 8'hFF : w_qual[7:0];
            s_utc = w_utc;
            s_sats = w_sats[7:0];
            s_hdop = w_hdop;
            if (has_lat && has_lon && qpos) begin
                s_lat = degrees(w_lat, lat_neg ^ lat_dir, 900000000);
                s_lon = degrees(w_lon, lon_neg ^ lon_dir, 1800000000);
                s_alt = w_alt;
                s_fix = 1;
            end else s_fix = 0;
        end
        r.fix_valid = s_fix;
        r.latitude = s_lat[30:0];
        r.longitude = s_lon;
        r.altitude = s_alt[24:0];
        r.satellites = s_sats;
        r.hdop = s_hdop[15:0];
        r.fix_quality = s_qual;
        r.utc_hhmmss = s_utc[17:0];
        r.sentence_total = gga_count;
        r.checksum_errors = csum_count;
        return r;
    endfunction

    // one accepted word; returns 1 and the expected result when a line begun with '$' closes
    function automatic bit parse_byte(bit [7:0] c, output t_result r);
        int unsigned p;
        if (c == 8'd10 || c == 8'd13) begin
            bit hit = (ln_len > 0) && ln_sent;
            if (hit) r = close_line();
            ln_len = 0;
            return hit;
        end
        if (ln_len < LIMIT - 1) begin
            p = ln_len++;
            if (p == 0) open_line(c);
            else if (ln_sent) sentence_char(p, c);
        end else ln_len = 0;
        return 0;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    byte unsigned pending[$];   // words waiting to be offered
    int           words_sent = 0;
    bit           sending_done = 0;

    function automatic string hex2(bit [7:0] v);
        return $sformatf("%02X", v);
    endfunction

    // wraps a body in '$', '*', checksum and CRLF
    function automatic void push_sentence(string body, bit bad_sum, bit lower);
        bit [7:0] x = 0;
        string s;
        for (int k = 0; k < body.len(); k++) x ^= body[k];
        if (bad_sum) x ^= 8'h01 << $urandom_range(7, 0);
        s = hex2(x);
        if (lower) s = s.tolower();
        push_text({"$", body, "*", s, "\r\n"});
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) pending.push_back(s[k]);
    endfunction

    function automatic string rnd_digits(int n);
        string s = "";
        for (int k = 0; k < n; k++) s = {s, string'(byte'("0" + $urandom_range(9, 0)))};
        return s;
    endfunction

    function automatic string rnd_num(int ni, int nf);
        string s = "";
        case ($urandom_range(9, 0))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        s = {s, rnd_digits(ni)};
        if (nf > 0 || $urandom_range(3, 0) == 0) s = {s, ".", rnd_digits(nf)};
        return s;
    endfunction

    function automatic string rnd_field(int ni, int nf);
        case ($urandom_range(19, 0))
            0: return "";
            1: return " 1";
            2: return "x";
            3: return rnd_digits($urandom_range(12, 0));
            default: return rnd_num(ni, nf);
        endcase
    endfunction

    function automatic string rnd_gga();
        string t = {"G", string'(byte'("A" + $urandom_range(25, 0)))};
        string b;
        int nf;
        b = {t, "GGA,", rnd_field(6, $urandom_range(3, 0)), ",",
             rnd_field(4, $urandom_range(8, 0)), ",", ($urandom_range(1, 0) ? "N" : "S"), ",",
             rnd_field(5, $urandom_range(8, 0)), ",", ($urandom_range(1, 0) ? "E" : "W"), ",",
             rnd_field($urandom_range(3, 1), 0), ",", rnd_field(2, 0), ",",
             rnd_field(2, $urandom_range(3, 0)), ",", rnd_field($urandom_range(8, 1), 2),
             ",M,46.9,M,,"};
        nf = $urandom_range(15, 0);
        if (nf == 0) begin  // truncate the body at a random point
            int cut = $urandom_range(b.len() - 1, 6);
            b = b.substr(0, cut - 1);
        end
        return b;
    endfunction

    function automatic void push_random_line();
        int sel = $urandom_range(99, 0);
        if (sel < 70) push_sentence(rnd_gga(), $urandom_range(9, 0) == 0, $urandom_range(1, 0));
        else if (sel < 78) push_sentence("GPRMC,1,2,3", 0, 0);
        else if (sel < 86) begin // random garbage, any byte
            int n = $urandom_range(20, 1);
            for (int k = 0; k < n; k++) pending.push_back(8'($urandom_range(255, 0)));
            pending.push_back(8'd10);
        end else if (sel < 92) begin // sentence with random broken tail
            push_text({"$", rnd_gga(), (($urandom_range(1, 0)) ? "*" : ""),
                       string'(byte'($urandom_range(255, 0))), "\n"});
        end else begin // overlong line that starts with '$'
            pending.push_back("$");
            for (int k = 0; k < LIMIT + $urandom_range(20, 0); k++) pending.push_back("1");
            pending.push_back(8'd13);
        end
    endfunction

    // Directed table: text of a line and, where it is obvious, its kind.
    typedef struct {
        string    text;
        bit       sum;     // append valid checksum
        bit       known;   // kind is typed in
        bit [1:0] kind;
    } t_row;

    t_row directed[] = '{
        '{"GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,",
          1, 1, KIND_OK},
        '{"$GPGGA,1,2,N,3,E,1,0,0,0*00\r\n", 0, 1, KIND_CSUM},
        '{"$*00\r\n", 0, 1, KIND_CSUM},
        '{"$GPGGA,1\r\n", 0, 1, KIND_CSUM},
        '{"$GPGGA*4\n", 0, 1, KIND_CSUM},
        '{"GPRMC,1,2", 1, 1, KIND_TYPE},
        '{"GPG", 1, 1, KIND_TYPE},
        '{"GPGGA,1,2,3", 1, 1, KIND_FEW},
        '{"XXGGA,235959,9000.00000,S,18000.00000,W,9,99,99.99,9999.9,M,,,,", 1, 0, 0},
        '{"GNGGA,999999,-5959.999999,S,-17959.99999,W,255,255,655.35,-99999.9,M",
          1, 0, 0},
        '{"GPGGA,,,,,,0,,,", 1, 0, 0},
        '{"GPGGA,1,9999999999.9,N,99999999,E,0.5,-3,-1.5,+12.34", 1, 0, 0},
        '{"GPGGA,1,0100,N,0100,E,1000,300,700.009,12345678.9,M", 1, 0, 0},
        '{"GPGGA,1,1e3,N,2,E,-1,1,1,1", 1, 0, 0},
        '{"GPGGA,1,1,N,2,E,1,1,1,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20",
          1, 0, 0},
        '{"no dollar line *00\r\n", 0, 0, 0},
        '{"\r\n\n\r", 0, 0, 0},
        '{"$GPGGA,1,2,N,3,E,1,0,0,0*ZZ\r\n", 0, 1, KIND_CSUM}
    };

    // ---------------------------------------------------------------
    // Sender: offers words, idles at random
    // ---------------------------------------------------------------
    int cycle_count = 0;
    int quiet = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic bit gap_now();
        // calm stretch with no idling in the middle of the run
        if (cycle_count > 900 && cycle_count < 1300) return 0;
        return $urandom_range(99, 0) < 16;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed part
        foreach (directed[k]) begin
            if (directed[k].sum) push_sentence(directed[k].text, 0, 0);
            else push_text(directed[k].text);
        end
        // a byte with the top bit set in a sentence line
        push_text({"$", string'(byte'(8'h80)), "\n"});
        while (words_sent < 1600 || pending.size() != 0) begin
            if (pending.size() == 0) push_random_line();
            if (in_ch.valid && in_ch.ready) begin
                // handled by monitor; move to next word below
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (!gap_now()) begin
                    in_ch.valid <= 1'b1;
                    in_ch.rx_byte <= pending.pop_front();
                    words_sent++;
                end else in_ch.valid <= 1'b0;
            end
            @(posedge i_clk);
        end
        while (in_ch.valid && !in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        @(posedge i_clk iff i_rst_n);
        repeat (300) begin
            out_ch.ready <= !gap_now();
            @(posedge i_clk);
        end
        out_ch.ready <= 1'b0;   // long hold-off: block must back up its input
        repeat (400) @(posedge i_clk);
        forever begin
            out_ch.ready <= !gap_now();
            @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Monitors and checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    int directed_seen = 0;
    int kinds_known[$];

    initial begin
        foreach (directed[k]) begin
            if (directed[k].text.len() > 0 && (directed[k].sum || directed[k].text[0] == "$"))
                kinds_known.push_back(directed[k].known ? directed[k].kind : -1);
        end
    end

    always @(posedge i_clk) begin
        t_result r, w;
        int tag;
        if (!i_rst_n) begin
            ln_len = 0;
            open_line(0);
            s_lat = 0; s_lon = 0; s_alt = 0; s_hdop = 0; s_utc = 0; s_sats = 0; s_qual = 0;
            s_fix = 0; gga_count = 0; csum_count = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                quiet <= 0;
                if (parse_byte(in_ch.rx_byte, r)) expected_results.push_back(r);
            end else if (out_ch.valid && out_ch.ready) quiet <= 0;
            else quiet <= quiet + 1;
            if (out_ch.valid && out_ch.ready) begin
                r = out_ch.res;
                if (expected_results.size() == 0) report_mismatch("unexpected result", 1, 0);
                else begin
                    w = expected_results.pop_front();
                    if (kinds_known.size() != 0) begin
                        tag = kinds_known.pop_front();
                        if (tag >= 0 && r.line_kind != tag[1:0])
                            report_mismatch("directed line_kind", r.line_kind, tag);
                    end
                    if (r.line_kind != w.line_kind)
                        report_mismatch("line_kind", r.line_kind, w.line_kind);
                    if (r.fix_valid != w.fix_valid)
                        report_mismatch("fix_valid", r.fix_valid, w.fix_valid);
                    if (r.latitude != w.latitude)
                        report_mismatch("latitude", r.latitude, w.latitude);
                    if (r.longitude != w.longitude)
                        report_mismatch("longitude", r.longitude, w.longitude);
                    if (r.altitude != w.altitude)
                        report_mismatch("altitude", r.altitude, w.altitude);
                    if (r.satellites != w.satellites)
                        report_mismatch("satellites", r.satellites, w.satellites);
                    if (r.hdop != w.hdop) report_mismatch("hdop", r.hdop, w.hdop);
                    if (r.fix_quality != w.fix_quality)
                        report_mismatch("fix_quality", r.fix_quality, w.fix_quality);
                    if (r.utc_hhmmss != w.utc_hhmmss)
                        report_mismatch("utc_hhmmss", r.utc_hhmmss, w.utc_hhmmss);
                    if (r.sentence_total != w.sentence_total)
                        report_mismatch("sentence_total", r.sentence_total, w.sentence_total);
                    if (r.checksum_errors != w.checksum_errors)
                        report_mismatch("checksum_errors", r.checksum_errors,
                                        w.checksum_errors);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // End of run and watchdog
    // ---------------------------------------------------------------
    initial begin
        @(posedge i_clk iff ((sending_done && expected_results.size() == 0)
                             || quiet >= WATCHDOG));
        if (quiet >= WATCHDOG) begin
            $display("nmea_gga_sentence_parser regression: fail");
        end else begin
            repeat (50) @(posedge i_clk);
            if (errors == 0 && expected_results.size() == 0) begin
                $display("nmea_gga_sentence_parser regression: pass");
            end else begin
                $display("nmea_gga_sentence_parser regression: fail");
            end
        end
        $finish;
    end
endmodule
`default_nettype wire
